FILE: design/tcw_pkg.sv
package tcw_pkg;

   localparam int SCREEN_ROWS = 25;
   localparam int SCREEN_COLS = 80;
   localparam int CELLS       = SCREEN_ROWS * SCREEN_COLS;
   localparam int ADDR_W      = $clog2(CELLS);

   localparam int SROW_W = 6;
   localparam int SCOL_W = 8;

   localparam logic [2:0] REQ_PUT   = 3'd0;
   localparam logic [2:0] REQ_CLEAR = 3'd1;
   localparam logic [2:0] REQ_SET   = 3'd2;
   localparam logic [2:0] REQ_WRITE = 3'd3;
   localparam logic [2:0] REQ_READ  = 3'd4;

   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_WIN_TOP    = 3'd0;
   localparam logic [2:0] REG_WIN_LEFT   = 3'd1;
   localparam logic [2:0] REG_WIN_HEIGHT = 3'd2;
   localparam logic [2:0] REG_WIN_WIDTH  = 3'd3;
   localparam logic [2:0] REG_TEXT_FG    = 3'd4;
   localparam logic [2:0] REG_TEXT_BG    = 3'd5;
   localparam logic [2:0] REG_CURSOR_ON  = 3'd6;

   localparam logic [7:0] CHR_CR = 8'h0D;
   localparam logic [7:0] CHR_LF = 8'h0A;

endpackage

FILE: design/text_console_writer.sv
// A request is taken only while idle and then runs in the exec state; a read cell also
// passes the finish state, and a clear or a put char that scrolls the frame walks its
// cells with one cell memory access per cycle. No new request is taken until the last
// response is loaded, so a stalled response also holds off the next request.
// Reset clears the control state and the caret and loads the register defaults.
// The cell memory is not cleared and holds its contents until written.
module text_console_writer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_type,
   input  logic [7:0]                     req_char_code,
   input  logic [4:0]                     req_cell_row,
   input  logic [6:0]                     req_cell_col,
   input  logic [3:0]                     req_cell_fg,
   input  logic [3:0]                     req_cell_bg,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_read_char,
   output logic [3:0]                     rsp_read_fg,
   output logic [3:0]                     rsp_read_bg,
   output logic [4:0]                     rsp_caret_row_out,
   output logic [6:0]                     rsp_caret_col_out,
   output logic [10:0]                    rsp_cursor_offset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_BLANK  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam int AW = tcw_pkg::ADDR_W;
   localparam int RW = tcw_pkg::SROW_W;
   localparam int CW = tcw_pkg::SCOL_W;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] srow,
                                               input logic [CW-1:0] scol);
      cell_addr = AW'(AW'(srow) * AW'(tcw_pkg::SCREEN_COLS) + AW'(scol));
   endfunction

   function automatic logic on_screen(input logic [RW-1:0] srow, input logic [CW-1:0] scol);
      on_screen = (32'(srow) < 32'(tcw_pkg::SCREEN_ROWS))
               && (32'(scol) < 32'(tcw_pkg::SCREEN_COLS));
   endfunction

   logic [4:0]  win_top_ff, win_height_ff;
   logic [6:0]  win_left_ff, win_width_ff;
   logic [3:0]  text_fg_ff, text_bg_ff;
   logic        cursor_on_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  pos_row_ff, pos_row_in;
   logic [6:0]  pos_col_ff, pos_col_in;
   logic [4:0]  wk_row_ff, wk_row_in;
   logic [6:0]  wk_col_ff, wk_col_in;

   logic [2:0]  op_type_ff;
   logic [7:0]  op_char_ff;
   logic [4:0]  op_row_ff;
   logic [6:0]  op_col_ff;
   logic [3:0]  op_fg_ff, op_bg_ff;

   logic [15:0] cell_mem_ff [tcw_pkg::CELLS];
   logic [15:0] rd_data_ff;
   logic        rd_hit_ff, rd_hit_in;
   logic        mem_re, mem_we;
   logic [AW-1:0] mem_raddr, mem_waddr;
   logic [15:0] mem_wdata;

   logic        stage_en_ff, stage_en_in;
   logic        stage_copy_ff, stage_copy_in;
   logic        stage_zero_ff, stage_zero_in;
   logic [AW-1:0] stage_addr_ff, stage_addr_in;

   logic        exec_we;
   logic [AW-1:0] exec_waddr;
   logic [15:0] exec_wdata;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_cell_ff;
   logic [4:0]  rsp_row_ff;
   logic [6:0]  rsp_col_ff;
   logic [10:0] rsp_offset_ff;
   logic        out_free, out_load;
   logic [15:0] out_cell;
   logic [10:0] out_offset;

   logic [4:0]  frame_h, crow, nl_row;
   logic [6:0]  frame_w, ccol;
   logic        nl_scroll, put_newline;
   logic [15:0] blank_cell;
   logic [RW-1:0] put_srow, dir_srow, wk_srow, wk_drow, cur_srow;
   logic [CW-1:0] put_scol, dir_scol, wk_scol;
   logic        wk_col_last, wk_row_last;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         win_top_ff    <= 5'd0;
         win_left_ff   <= 7'd0;
         win_height_ff <= 5'd25;
         win_width_ff  <= 7'd80;
         text_fg_ff    <= 4'd15;
         text_bg_ff    <= 4'd1;
         cursor_on_ff  <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            tcw_pkg::REG_WIN_TOP:    win_top_ff    <= csr_pwdata[4:0];
            tcw_pkg::REG_WIN_LEFT:   win_left_ff   <= csr_pwdata[6:0];
            tcw_pkg::REG_WIN_HEIGHT: win_height_ff <= csr_pwdata[4:0];
            tcw_pkg::REG_WIN_WIDTH:  win_width_ff  <= csr_pwdata[6:0];
            tcw_pkg::REG_TEXT_FG:    text_fg_ff    <= csr_pwdata[3:0];
            tcw_pkg::REG_TEXT_BG:    text_bg_ff    <= csr_pwdata[3:0];
            tcw_pkg::REG_CURSOR_ON:  cursor_on_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tcw_pkg::REG_WIN_TOP:    csr_prdata = {27'd0, win_top_ff};
         tcw_pkg::REG_WIN_LEFT:   csr_prdata = {25'd0, win_left_ff};
         tcw_pkg::REG_WIN_HEIGHT: csr_prdata = {27'd0, win_height_ff};
         tcw_pkg::REG_WIN_WIDTH:  csr_prdata = {25'd0, win_width_ff};
         tcw_pkg::REG_TEXT_FG:    csr_prdata = {28'd0, text_fg_ff};
         tcw_pkg::REG_TEXT_BG:    csr_prdata = {28'd0, text_bg_ff};
         tcw_pkg::REG_CURSOR_ON:  csr_prdata = {31'd0, cursor_on_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   assign frame_h    = (win_height_ff == 5'd0) ? 5'd1 : win_height_ff;
   assign frame_w    = (win_width_ff == 7'd0) ? 7'd1 : win_width_ff;
   assign blank_cell = {text_bg_ff, text_fg_ff, 8'h00};

   assign crow = (pos_row_ff >= frame_h) ? 5'(frame_h - 5'd1) : pos_row_ff;
   assign ccol = (pos_col_ff >= frame_w) ? 7'(frame_w - 7'd1) : pos_col_ff;

   assign nl_scroll = ({1'b0, crow} + 6'd1) >= {1'b0, frame_h};
   assign nl_row    = nl_scroll ? 5'(frame_h - 5'd1) : 5'(crow + 5'd1);
   assign put_newline = (op_char_ff == tcw_pkg::CHR_LF)
                     || ((op_char_ff != tcw_pkg::CHR_CR)
                         && (({1'b0, ccol} + 8'd1) >= {1'b0, frame_w}));

   assign put_srow = RW'({1'b0, win_top_ff} + {1'b0, crow});
   assign put_scol = CW'({1'b0, win_left_ff} + {1'b0, ccol});
   assign dir_srow = RW'({1'b0, op_row_ff});
   assign dir_scol = CW'({1'b0, op_col_ff});
   assign wk_srow  = RW'({1'b0, win_top_ff} + {1'b0, wk_row_ff});
   assign wk_drow  = RW'(wk_srow - RW'(1));
   assign wk_scol  = CW'({1'b0, win_left_ff} + {1'b0, wk_col_ff});

   assign wk_col_last = (wk_col_ff == 7'(frame_w - 7'd1));
   assign wk_row_last = (wk_row_ff == 5'(frame_h - 5'd1));

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      pos_row_in    = pos_row_ff;
      pos_col_in    = pos_col_ff;
      wk_row_in     = wk_row_ff;
      wk_col_in     = wk_col_ff;
      rd_hit_in     = rd_hit_ff;
      mem_re        = 1'b0;
      mem_raddr     = cell_addr(dir_srow, dir_scol);
      exec_we       = 1'b0;
      exec_waddr    = cell_addr(dir_srow, dir_scol);
      exec_wdata    = {op_bg_ff, op_fg_ff, op_char_ff};
      stage_en_in   = 1'b0;
      stage_copy_in = 1'b0;
      stage_zero_in = 1'b0;
      stage_addr_in = cell_addr(wk_srow, wk_scol);
      out_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rd_hit_in = 1'b0;
            state_in  = ST_FINISH;
            case (op_type_ff)
               tcw_pkg::REQ_PUT: begin
                  pos_row_in = crow;
                  pos_col_in = (op_char_ff == tcw_pkg::CHR_CR) ? 7'd0 : 7'(ccol + 7'd1);
                  if ((op_char_ff != tcw_pkg::CHR_CR) && (op_char_ff != tcw_pkg::CHR_LF)) begin
                     exec_we    = on_screen(put_srow, put_scol);
                     exec_waddr = cell_addr(put_srow, put_scol);
                     exec_wdata = {text_bg_ff, text_fg_ff, op_char_ff};
                  end
                  if (put_newline) begin
                     pos_row_in = nl_row;
                     pos_col_in = 7'd0;
                     if (nl_scroll) begin
                        wk_col_in = 7'd0;
                        if (frame_h > 5'd1) begin
                           wk_row_in = 5'd1;
                           state_in  = ST_SCROLL;
                        end else begin
                           wk_row_in = 5'd0;
                           state_in  = ST_BLANK;
                        end
                     end
                  end
               end
               tcw_pkg::REQ_CLEAR: begin
                  wk_row_in = 5'd0;
                  wk_col_in = 7'd0;
                  state_in  = ST_BLANK;
               end
               tcw_pkg::REQ_SET: begin
                  pos_row_in = (op_row_ff >= frame_h) ? 5'(frame_h - 5'd1) : op_row_ff;
                  pos_col_in = (op_col_ff >= frame_w) ? 7'(frame_w - 7'd1) : op_col_ff;
               end
               tcw_pkg::REQ_WRITE: begin
                  exec_we = on_screen(dir_srow, dir_scol);
               end
               tcw_pkg::REQ_READ: begin
                  mem_re    = on_screen(dir_srow, dir_scol);
                  rd_hit_in = on_screen(dir_srow, dir_scol);
               end
               default: ;
            endcase
            if ((state_in == ST_FINISH) && (op_type_ff != tcw_pkg::REQ_READ) && out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            mem_re        = 1'b1;
            mem_raddr     = cell_addr(wk_srow, wk_scol);
            stage_en_in   = on_screen(wk_drow, wk_scol);
            stage_copy_in = 1'b1;
            stage_zero_in = !on_screen(wk_srow, wk_scol);
            stage_addr_in = cell_addr(wk_drow, wk_scol);
            if (wk_col_last) begin
               wk_col_in = 7'd0;
               if (wk_row_last) begin
                  state_in = ST_BLANK;
               end else begin
                  wk_row_in = 5'(wk_row_ff + 5'd1);
               end
            end else begin
               wk_col_in = 7'(wk_col_ff + 7'd1);
            end
         end
         ST_BLANK: begin
            stage_en_in = on_screen(wk_srow, wk_scol);
            if (wk_col_last) begin
               wk_col_in = 7'd0;
               if (wk_row_last) begin
                  state_in = ST_FINISH;
               end else begin
                  wk_row_in = 5'(wk_row_ff + 5'd1);
               end
            end else begin
               wk_col_in = 7'(wk_col_ff + 7'd1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (stage_en_ff) begin
         mem_we    = 1'b1;
         mem_waddr = stage_addr_ff;
         if (!stage_copy_ff) begin
            mem_wdata = blank_cell;
         end else if (stage_zero_ff) begin
            mem_wdata = 16'd0;
         end else begin
            mem_wdata = rd_data_ff;
         end
      end else begin
         mem_we    = exec_we;
         mem_waddr = exec_waddr;
         mem_wdata = exec_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cell_mem_ff[mem_raddr];
      end
   end

   assign cur_srow   = RW'({1'b0, win_top_ff} + {1'b0, pos_row_in});
   assign out_offset = cursor_on_ff
                     ? 11'(11'(cur_srow) * 11'(tcw_pkg::SCREEN_COLS)
                           + 11'(win_left_ff) + 11'(pos_col_in))
                     : 11'(tcw_pkg::CELLS);
   assign out_cell   = ((state_ff == ST_FINISH) && rd_hit_ff) ? rd_data_ff : 16'd0;
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_row_ff   <= 5'd0;
         pos_col_ff   <= 7'd0;
         rsp_valid_ff <= 1'b0;
         stage_en_ff  <= 1'b0;
         rd_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_row_ff   <= pos_row_in;
         pos_col_ff   <= pos_col_in;
         rsp_valid_ff <= rsp_valid_in;
         stage_en_ff  <= stage_en_in;
         rd_hit_ff    <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_row_ff     <= wk_row_in;
      wk_col_ff     <= wk_col_in;
      stage_copy_ff <= stage_copy_in;
      stage_zero_ff <= stage_zero_in;
      stage_addr_ff <= stage_addr_in;
      if (req_valid && !req_stall) begin
         op_type_ff <= req_type;
         op_char_ff <= req_char_code;
         op_row_ff  <= req_cell_row;
         op_col_ff  <= req_cell_col;
         op_fg_ff   <= req_cell_fg;
         op_bg_ff   <= req_cell_bg;
      end
      if (out_load) begin
         rsp_cell_ff   <= out_cell;
         rsp_row_ff    <= pos_row_in;
         rsp_col_ff    <= pos_col_in;
         rsp_offset_ff <= out_offset;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_char     = rsp_cell_ff[7:0];
   assign rsp_read_fg       = rsp_cell_ff[11:8];
   assign rsp_read_bg       = rsp_cell_ff[15:12];
   assign rsp_caret_row_out = rsp_row_ff;
   assign rsp_caret_col_out = rsp_col_ff;
   assign rsp_cursor_offset = rsp_offset_ff;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
   localparam logic [2:0] REQ_BAD_LAST  = 3'd7;
   localparam int QUIET_LIMIT   = 10000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0]  read_char;
      logic [3:0]  read_fg;
      logic [3:0]  read_bg;
      logic [4:0]  pos_row;
      logic [6:0]  pos_col;
      logic [10:0] cursor_offset;
   } console_status_type;

   logic                           clock         = 1'b0;
   logic                           reset         = 1'b1;
   logic                           req_valid     = 1'b0;
   logic                           req_stall;
   logic [2:0]                     req_type      = tcw_pkg::REQ_PUT;
   logic [7:0]                     req_char_code = '0;
   logic [4:0]                     req_cell_row  = '0;
   logic [6:0]                     req_cell_col  = '0;
   logic [3:0]                     req_cell_fg   = '0;
   logic [3:0]                     req_cell_bg   = '0;
   logic                           rsp_valid;
   logic                           rsp_stall     = 1'b0;
   logic [7:0]                     rsp_read_char;
   logic [3:0]                     rsp_read_fg;
   logic [3:0]                     rsp_read_bg;
   logic [4:0]                     rsp_caret_row_out;
   logic [6:0]                     rsp_caret_col_out;
   logic [10:0]                    rsp_cursor_offset;
   logic                           csr_psel      = 1'b0;
   logic                           csr_penable   = 1'b0;
   logic                           csr_pwrite    = 1'b0;
   logic [tcw_pkg::CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [31:0]                    csr_pwdata    = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   text_console_writer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .req_cell_row      (req_cell_row),
      .req_cell_col      (req_cell_col),
      .req_cell_fg       (req_cell_fg),
      .req_cell_bg       (req_cell_bg),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_fg       (rsp_read_fg),
      .rsp_read_bg       (rsp_read_bg),
      .rsp_caret_row_out (rsp_caret_row_out),
      .rsp_caret_col_out (rsp_caret_col_out),
      .rsp_cursor_offset (rsp_cursor_offset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   // Shadow copy of the console: cell memory, caret and frame registers.
   logic [15:0] screen_copy [tcw_pkg::CELLS];
   int caret_r = 0;
   int caret_c = 0;
   int win_top = 0;
   int win_left = 0;
   int win_height = 25;
   int win_width = 80;
   int text_fg = 15;
   int text_bg = 1;
   int cursor_on = 1;

   console_status_type caret_reports [$];

   int mismatches = 0;
   int checked = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 26;
   int recv_idle_pct = 63;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;

   function automatic int rows_in_frame();
      return (win_height == 0) ? 1 : win_height;
   endfunction

   function automatic int cols_in_frame();
      return (win_width == 0) ? 1 : win_width;
   endfunction

   function automatic logic [15:0] cell_at(int r, int c);
      if (r >= tcw_pkg::SCREEN_ROWS || c >= tcw_pkg::SCREEN_COLS) begin
         return 16'h0000;
      end
      return screen_copy[r * tcw_pkg::SCREEN_COLS + c];
   endfunction

   function automatic void put_cell(int r, int c, logic [15:0] value);
      if (r < tcw_pkg::SCREEN_ROWS && c < tcw_pkg::SCREEN_COLS) begin
         screen_copy[r * tcw_pkg::SCREEN_COLS + c] = value;
      end
   endfunction

   function automatic void blank_line(int r);
      for (int c = 0; c < cols_in_frame(); c++) begin
         put_cell(win_top + r, win_left + c, {text_bg[3:0], text_fg[3:0], 8'h00});
      end
   endfunction

   function automatic void clamp_caret();
      if (caret_r >= rows_in_frame()) begin
         caret_r = rows_in_frame() - 1;
      end
      if (caret_c >= cols_in_frame()) begin
         caret_c = cols_in_frame() - 1;
      end
   endfunction

   // Passing the bottom row scrolls the frame up one row and blanks its last row.
   function automatic void next_line();
      caret_c = 0;
      if (caret_r + 1 >= rows_in_frame()) begin
         caret_r = rows_in_frame() - 1;
         for (int r = 1; r < rows_in_frame(); r++) begin
            for (int c = 0; c < cols_in_frame(); c++) begin
               put_cell(win_top + r - 1, win_left + c, cell_at(win_top + r, win_left + c));
            end
         end
         blank_line(rows_in_frame() - 1);
      end else begin
         caret_r++;
      end
   endfunction

   function automatic void apply_request(logic [2:0] kind, logic [7:0] code, logic [4:0] row,
                                         logic [6:0] col, logic [3:0] fg, logic [3:0] bg);
      logic [15:0] rd;
      int off;
      console_status_type s;
      rd = '0;
      case (kind)
         tcw_pkg::REQ_PUT: begin
            clamp_caret();
            if (code == tcw_pkg::CHR_CR) begin
               caret_c = 0;
            end else if (code == tcw_pkg::CHR_LF) begin
               next_line();
            end else begin
               put_cell(win_top + caret_r, win_left + caret_c,
                        {text_bg[3:0], text_fg[3:0], code});
               caret_c++;
               if (caret_c >= cols_in_frame()) begin
                  next_line();
               end
            end
         end
         tcw_pkg::REQ_CLEAR: begin
            for (int r = 0; r < rows_in_frame(); r++) begin
               blank_line(r);
            end
         end
         tcw_pkg::REQ_SET: begin
            caret_r = int'(row);
            caret_c = int'(col);
            clamp_caret();
         end
         tcw_pkg::REQ_WRITE: put_cell(int'(row), int'(col), {bg, fg, code});
         tcw_pkg::REQ_READ: rd = cell_at(int'(row), int'(col));
         default: ;
      endcase
      if (cursor_on != 0) begin
         off = (win_top + caret_r) * tcw_pkg::SCREEN_COLS + win_left + caret_c;
      end else begin
         off = tcw_pkg::CELLS;
      end
      s.read_char     = rd[7:0];
      s.read_fg       = rd[11:8];
      s.read_bg       = rd[15:12];
      s.pos_row       = caret_r[4:0];
      s.pos_col       = caret_c[6:0];
      s.cursor_offset = off[10:0];
      caret_reports.push_back(s);
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic [2:0] kind, input logic [7:0] code,
                               input logic [4:0] row, input logic [6:0] col,
                               input logic [3:0] fg, input logic [3:0] bg);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_char_code <= code;
      req_cell_row  <= row;
      req_cell_col  <= col;
      req_cell_fg   <= fg;
      req_cell_bg   <= bg;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      apply_request(kind, code, row, col, fg, bg);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (caret_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      case (index)
         tcw_pkg::REG_WIN_TOP:    win_top    = value & 'h1F;
         tcw_pkg::REG_WIN_LEFT:   win_left   = value & 'h7F;
         tcw_pkg::REG_WIN_HEIGHT: win_height = value & 'h1F;
         tcw_pkg::REG_WIN_WIDTH:  win_width  = value & 'h7F;
         tcw_pkg::REG_TEXT_FG:    text_fg    = value & 'hF;
         tcw_pkg::REG_TEXT_BG:    text_bg    = value & 'hF;
         tcw_pkg::REG_CURSOR_ON:  cursor_on  = value & 'h1;
         default: ;
      endcase
   endtask

   task automatic set_frame(input int top, input int left, input int height, input int width,
                            input int fg, input int bg, input int shown);
      wait_drained();
      csr_write(tcw_pkg::REG_WIN_TOP, top);
      csr_write(tcw_pkg::REG_WIN_LEFT, left);
      csr_write(tcw_pkg::REG_WIN_HEIGHT, height);
      csr_write(tcw_pkg::REG_WIN_WIDTH, width);
      csr_write(tcw_pkg::REG_TEXT_FG, fg);
      csr_write(tcw_pkg::REG_TEXT_BG, bg);
      csr_write(tcw_pkg::REG_CURSOR_ON, shown);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly text with line breaks; scattered cell accesses lean toward the frame.
   task automatic run_random(input int count);
      logic [2:0] kind;
      logic [7:0] code;
      logic [4:0] row;
      logic [6:0] col;
      int pick;
      int sub;
      int clear_pct;
      for (int n = 0; n < count; n++) begin
         clear_pct = (rows_in_frame() * cols_in_frame() > 400) ? 1 : 4;
         pick = $urandom_range(0, 99);
         code = 8'($urandom_range(0, 255));
         row = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 24));
         col = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 79));
         if (pick < 55) begin
            kind = tcw_pkg::REQ_PUT;
            sub = $urandom_range(0, 99);
            if (sub < 10) begin
               code = tcw_pkg::CHR_CR;
            end else if (sub < 22) begin
               code = tcw_pkg::CHR_LF;
            end
         end else if (pick < 55 + clear_pct) begin
            kind = tcw_pkg::REQ_CLEAR;
         end else if (pick < 66) begin
            kind = tcw_pkg::REQ_SET;
            if ($urandom_range(0, 9) != 0) begin
               row = 5'($urandom_range(0, rows_in_frame()));
               col = 7'($urandom_range(0, cols_in_frame()));
            end
         end else if (pick < 96) begin
            kind = (pick < 80) ? tcw_pkg::REQ_WRITE : tcw_pkg::REQ_READ;
            if ($urandom_range(0, 1) == 1) begin
               row = 5'(win_top + $urandom_range(0, rows_in_frame() - 1));
               col = 7'(win_left + $urandom_range(0, cols_in_frame() - 1));
            end
         end else begin
            kind = 3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST));
         end
         send_request(kind, code, row, col, 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)));
      end
   endtask

   task automatic test_clear_and_put();
      send_request(tcw_pkg::REQ_CLEAR, 8'h00, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_PUT, 8'h00, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_PUT, 8'hFF, 5'd31, 7'd127, 4'd15, 4'd15);
      send_request(tcw_pkg::REQ_PUT, 8'h41, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_PUT, tcw_pkg::CHR_CR, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_PUT, tcw_pkg::CHR_LF, 5'd0, 7'd0, 4'd0, 4'd0);
   endtask

   task automatic test_cell_access();
      send_request(tcw_pkg::REQ_WRITE, 8'h00, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_WRITE, 8'hFF, 5'd24, 7'd79, 4'd15, 4'd15);
      send_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_READ, 8'h00, 5'd24, 7'd79, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_WRITE, 8'h5A, 5'd31, 7'd127, 4'd9, 4'd6);
      send_request(tcw_pkg::REQ_READ, 8'h00, 5'd31, 7'd127, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_READ, 8'h00, 5'd25, 7'd0, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd80, 4'd0, 4'd0);
   endtask

   task automatic test_caret_moves();
      send_request(tcw_pkg::REQ_SET, 8'h00, 5'd31, 7'd127, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_PUT, 8'h5A, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_SET, 8'h00, 5'd24, 7'd5, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_PUT, tcw_pkg::CHR_LF, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tcw_pkg::REQ_SET, 8'h00, 5'd0, 7'd0, 4'd0, 4'd0);
   endtask

   task automatic test_unknown_requests();
      send_request(REQ_BAD_FIRST, 8'hFF, 5'd31, 7'd127, 4'd15, 4'd15);
      send_request(REQ_BAD_FIRST + 3'd1, 8'h0A, 5'd3, 7'd4, 4'd5, 4'd6);
      send_request(REQ_BAD_LAST, 8'h0D, 5'd0, 7'd0, 4'd0, 4'd0);
   endtask

   task automatic test_default_frame();
      set_frame(0, 0, 25, 80, 15, 1, 1);
      run_random(60);
   endtask

   task automatic test_corner_frames();
      set_frame(0, 0, 1, 1, 0, 0, 1);
      run_random(120);
      set_frame(24, 79, 1, 1, 15, 15, 0);
      run_random(100);
   endtask

   task automatic test_edge_frames();
      set_frame(20, 70, 5, 10, 7, 8, 1);
      run_random(150);
      set_frame(22, 75, 6, 10, 3, 12, 1);
      run_random(120);
   endtask

   task automatic test_empty_frame();
      set_frame(3, 5, 0, 0, 9, 2, 1);
      run_random(100);
   endtask

   task automatic test_shaped_frames();
      set_frame(2, 10, 8, 16, 10, 5, 1);
      run_random(200);
      set_frame(0, 0, 25, 3, 1, 14, 1);
      run_random(80);
      set_frame(10, 0, 3, 80, 12, 3, 0);
      run_random(150);
   endtask

   task automatic test_random_frames();
      for (int k = 0; k < 4; k++) begin
         set_frame($urandom_range(0, 24), $urandom_range(0, 79), $urandom_range(1, 8),
                   $urandom_range(1, 24), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 1));
         run_random(70);
      end
   endtask

   // The response side holds off long enough for the block to back up into its input.
   task automatic test_backpressure();
      set_frame(4, 20, 4, 12, 2, 0, 1);
      hold_token++;
      run_random(40);
   endtask

   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      console_status_type got;
      console_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_read_char, rsp_read_fg, rsp_read_bg, rsp_caret_row_out,
                rsp_caret_col_out, rsp_cursor_offset};
         if (caret_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: response with no request pending: %p", got);
            end
         end else begin
            want = caret_reports.pop_front();
            if (got.read_char !== want.read_char || got.read_fg !== want.read_fg ||
                got.read_bg !== want.read_bg || got.pos_row !== want.pos_row ||
                got.pos_col !== want.pos_col ||
                got.cursor_offset !== want.cursor_offset) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: response %0d char/fg/bg/row/col/offset", checked);
                  $display("   expected %h %h %h %0d %0d %0d", want.read_char, want.read_fg,
                           want.read_bg, want.pos_row, want.pos_col, want.cursor_offset);
                  $display("   actual   %h %h %h %0d %0d %0d", got.read_char, got.read_fg,
                           got.read_bg, got.pos_row, got.pos_col, got.cursor_offset);
               end
            end
         end
         checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_clear_and_put();
      test_cell_access();
      test_caret_moves();
      test_unknown_requests();
      test_default_frame();
      test_corner_frames();

      send_idle_pct = 63;
      recv_idle_pct = 26;
      test_edge_frames();
      test_empty_frame();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_shaped_frames();
      test_random_frames();
      test_backpressure();

      wait_drained();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
